@@ sv/srbf_pkg.sv @@
// shared types, codes and constants of the sorted region best-fit allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package srbf_pkg;

	localparam int TABLE_DEPTH_DEF = 64;

	localparam logic [1:0] ACT_ADD    = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;
	localparam logic [1:0] ACT_LOOKUP = 2'd2;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_REJECT    = 2'd1;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
	localparam logic [1:0] STAT_FULL      = 2'd3;

	localparam int F_USER    = 0;
	localparam int F_KERNEL  = 1;
	localparam int F_SHARED  = 2;
	localparam int F_PRIVATE = 3;
	localparam int F_ANON    = 4;
	localparam int F_FILE    = 5;

	localparam logic [31:0] USER_TOP   = 32'hC000_0000;
	localparam logic [31:0] KERN_LOW   = 32'hC020_0000;
	localparam logic [31:0] KERN_HIGH  = 32'hFFD0_0000;
	localparam logic [31:0] PAGE_MASK  = 32'h0000_0FFF;
	localparam logic [31:0] LCG_MUL    = 32'd1103515245;
	localparam logic [31:0] LCG_INC    = 32'd12345;
	localparam logic [31:0] SEED_RESET = 32'd4;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] address;
		logic [31:0] length;
		logic [6:0]  map_flags;
		logic [15:0] file_handle;
		logic [31:0] file_offset;
		logic [31:0] disk_size;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] region_start;
		logic [31:0] region_length;
		logic [6:0]  region_flags;
		logic [15:0] region_file;
		logic [31:0] region_file_offset;
		logic [31:0] region_disk_size;
	} rsp_t;

	typedef struct packed {
		logic [31:0] base;
		logic [31:0] size;
		logic [6:0]  flags;
		logic [15:0] file;
		logic [31:0] offset;
		logic [31:0] disk;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	localparam entry_t SENTINEL = '{base: 32'hFFFF_FFFF, size: '0, flags: '0,
		file: '0, offset: '0, disk: '0};

	typedef enum logic [4:0] {
		S_IDLE,
		S_CHECK,
		S_UDRAW,
		S_UAPPLY,
		S_KCHK,
		S_KDRAW,
		S_KAPPLY,
		S_SCAN_START,
		S_RETRY,
		S_SCAN_A,
		S_SCAN_B,
		S_INS_RD,
		S_INS_WR,
		S_INS_SLOT,
		S_FIND_START,
		S_FIND_A,
		S_REM_ZERO,
		S_REM_RD,
		S_REM_WR,
		S_FINISH
	} state_t;

endpackage

`default_nettype wire

@@ sv/srbf_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module srbf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ sv/srbf_lcg.sv @@
// linear congruential generator for the window clamp, one draw per step
// depends on srbf_pkg
`timescale 1ns / 1ps
`default_nettype none

module srbf_lcg (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	output logic      [14:0] rand_val
);
	import srbf_pkg::*;

	logic [31:0] seed_q;
	logic [31:0] seed_next;

	assign seed_next = seed_q * LCG_MUL + LCG_INC;
	// (seed / 65536) mod 32768
	assign rand_val  = seed_q[30:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RESET;
		end else if (step) begin
			seed_q <= seed_next;
		end
	end

endmodule

`default_nettype wire

@@ sv/sorted_region_best_fit_allocator_core.sv @@
// Region table allocator: keeps up to TABLE_DEPTH - 1 address regions sorted by base in
// one single-port-read memory, with a sentinel at base 0xFFFFFFFF after reset. Add checks
// its flags, clamps the hint into the user or kernel window with a random 15-bit value,
// aligns it to 4 KiB, inserts it if the gap is free and otherwise retries once at the
// best-fit gap; remove deletes by exact base, though a region at base 0 only has its size
// cleared; lookup returns the region holding an address. One request is worked at a time
// and req_stall stays high until its result is in the output register. An add scans the
// table at most twice and shifts entries from its slot up by one; remove and lookup scan
// from entry 0, and remove shifts later entries down by one, paced by the one memory read
// per cycle and the single gap compare datapath. No clearing pass is needed after reset.
// depends on srbf_pkg, srbf_ram, srbf_lcg
`timescale 1ns / 1ps
`default_nettype none

module sorted_region_best_fit_allocator_core #(
	parameter int TABLE_DEPTH = srbf_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire srbf_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output srbf_pkg::rsp_t     rsp
);
	import srbf_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	state_t state_q, state_d;

	req_t        req_q;
	rsp_t        res_q, rsp_q;
	logic        rsp_valid_q;
	logic [31:0] hint_q, hintend_q, prev_end_q, new_end_q, diff_q;
	logic [31:0] cand_q, cand_slack_q;
	logic        cand_ok_q, pass_q;
	logic [AW-1:0] idx_q, slot_q, k_q;
	logic [CW-1:0] count_q;
	logic        e0_written_q, rd_zero_s1;

	// memory port
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	entry_t        ram_wentry;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t        ent;

	logic          lcg_step;
	logic [14:0]   rand_val;

	srbf_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wentry),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	srbf_lcg u_lcg (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (lcg_step),
		.rand_val (rand_val)
	);

	// entry zero reads as the sentinel until it is first written
	assign ent = rd_zero_s1 ? SENTINEL : entry_t'(ram_rdata);

	logic        accept;
	logic        flag_bad, user_hit, kern_hit, fit_now, last, contain;
	logic        allowed, cand_hit, take;
	logic [31:0] hint_sum, hint_align, pe_sz, slack;
	logic [CW-1:0] idx_ext, k_ext;

	assign accept     = req_valid && !req_stall;
	assign take       = !rsp_valid_q || !rsp_stall;
	assign idx_ext    = CW'(idx_q);
	assign k_ext      = CW'(k_q);
	assign last       = (idx_ext + CW'(1)) == count_q;

	assign flag_bad = (req_q.map_flags[F_USER] && req_q.map_flags[F_KERNEL]) ||
		(req_q.map_flags[F_SHARED] && req_q.map_flags[F_PRIVATE]) ||
		(req_q.map_flags[F_ANON] && req_q.map_flags[F_FILE]) ||
		(req_q.map_flags[F_FILE] && (req_q.file_handle == 16'd0));

	assign hint_sum   = hint_q + req_q.length;
	assign hint_align = hint_q & ~PAGE_MASK;
	assign user_hit   = req_q.map_flags[F_USER] && (hint_sum >= USER_TOP);
	assign kern_hit   = req_q.map_flags[F_KERNEL] &&
		((hint_q < KERN_LOW) || (hint_sum > KERN_HIGH));

	assign fit_now = (idx_q == '0) ? (ent.base > hintend_q) :
		((prev_end_q <= hint_q) && (ent.base > hintend_q));

	// second phase of a gap: is its start allowed and is it the tightest so far
	assign pe_sz   = prev_end_q + req_q.length;
	assign allowed = !(req_q.map_flags[F_USER] && (pe_sz >= USER_TOP)) &&
		!(req_q.map_flags[F_KERNEL] && ((prev_end_q < KERN_LOW) || (pe_sz > KERN_HIGH)));
	assign slack    = diff_q - req_q.length;
	assign cand_hit = (idx_q != '0) && !pass_q && (diff_q >= req_q.length) && allowed &&
		(!cand_ok_q || (slack < cand_slack_q));

	assign contain = (req_q.address >= ent.base) && (req_q.address < (ent.base + ent.size));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req.action == ACT_ADD) begin
						state_d = S_CHECK;
					end else if (req.action == ACT_REMOVE || req.action == ACT_LOOKUP) begin
						state_d = S_FIND_START;
					end else begin
						state_d = S_FINISH;
					end
				end
			end
			S_CHECK: begin
				if (flag_bad || count_q >= CW'(TABLE_DEPTH)) begin
					state_d = S_FINISH;
				end else if (user_hit) begin
					state_d = S_UDRAW;
				end else begin
					state_d = S_KCHK;
				end
			end
			S_UDRAW:      state_d = S_UAPPLY;
			S_UAPPLY:     state_d = S_KCHK;
			S_KCHK:       state_d = kern_hit ? S_KDRAW : S_SCAN_START;
			S_KDRAW:      state_d = S_KAPPLY;
			S_KAPPLY:     state_d = S_SCAN_START;
			S_SCAN_START: state_d = S_SCAN_A;
			S_RETRY:      state_d = S_SCAN_A;
			S_SCAN_A:     state_d = fit_now ? S_INS_RD : S_SCAN_B;
			S_SCAN_B: begin
				if (!last) begin
					state_d = S_SCAN_A;
				end else if (!pass_q && (cand_ok_q || cand_hit)) begin
					state_d = S_RETRY;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_INS_RD:     state_d = S_INS_WR;
			S_INS_WR:     state_d = ((k_q - AW'(1)) == slot_q) ? S_INS_SLOT : S_INS_RD;
			S_INS_SLOT:   state_d = S_FINISH;
			S_FIND_START: state_d = S_FIND_A;
			S_FIND_A: begin
				if (contain) begin
					if (req_q.action == ACT_LOOKUP || ent.base != req_q.address || last) begin
						state_d = S_FINISH;
					end else if (ent.base == 32'd0) begin
						state_d = S_REM_ZERO;
					end else begin
						state_d = S_REM_RD;
					end
				end else if (last) begin
					state_d = S_FINISH;
				end
			end
			S_REM_ZERO:   state_d = S_FINISH;
			S_REM_RD:     state_d = S_REM_WR;
			S_REM_WR:     state_d = ((k_ext + CW'(2)) < count_q) ? S_REM_RD : S_FINISH;
			S_FINISH:     state_d = take ? S_IDLE : S_FINISH;
			default:      state_d = S_IDLE;
		endcase
	end

	// memory and generator controls
	always_comb begin
		ram_re     = 1'b0;
		ram_raddr  = '0;
		ram_we     = 1'b0;
		ram_waddr  = '0;
		ram_wentry = ent;
		lcg_step   = 1'b0;
		unique case (state_q)
			S_UDRAW, S_KDRAW: lcg_step = 1'b1;
			S_SCAN_START, S_RETRY, S_FIND_START: ram_re = 1'b1;
			S_SCAN_B: begin
				ram_re    = !last;
				ram_raddr = idx_q + AW'(1);
			end
			S_FIND_A: begin
				ram_re    = !contain && !last;
				ram_raddr = idx_q + AW'(1);
			end
			S_INS_RD: begin
				ram_re    = 1'b1;
				ram_raddr = k_q - AW'(1);
			end
			S_INS_WR: begin
				ram_we    = 1'b1;
				ram_waddr = k_q;
			end
			S_INS_SLOT: begin
				ram_we     = 1'b1;
				ram_waddr  = slot_q;
				ram_wentry = '{base: hint_q, size: req_q.length, flags: req_q.map_flags,
					file: req_q.file_handle, offset: req_q.file_offset,
					disk: req_q.disk_size};
			end
			S_REM_ZERO: begin
				ram_we          = 1'b1;
				ram_waddr       = idx_q;
				ram_wentry.size = 32'd0;
			end
			S_REM_RD: begin
				ram_re    = 1'b1;
				ram_raddr = k_q + AW'(1);
			end
			S_REM_WR: begin
				ram_we    = 1'b1;
				ram_waddr = k_q;
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= CW'(1);
			e0_written_q <= 1'b0;
			rd_zero_s1   <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ram_we && ram_waddr == '0) begin
				e0_written_q <= 1'b1;
			end
			if (ram_re) begin
				rd_zero_s1 <= (ram_raddr == '0) && !e0_written_q;
			end
			if (state_q == S_INS_SLOT) begin
				count_q <= count_q + CW'(1);
			end
			if ((state_q == S_FIND_A && state_d == S_FINISH && contain && last &&
				req_q.action == ACT_REMOVE && ent.base == req_q.address &&
				ent.base != 32'd0) ||
				(state_q == S_REM_WR && state_d == S_FINISH)) begin
				count_q <= count_q - CW'(1);
			end
			if (state_q == S_FINISH && take) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					req_q  <= req;
					hint_q <= req.address;
					res_q  <= rsp_t'{status: (req.action == ACT_ADD ||
						req.action == ACT_REMOVE || req.action == ACT_LOOKUP) ?
						STAT_OK : STAT_REJECT, default: '0};
				end
			end
			S_CHECK: begin
				if (flag_bad) begin
					res_q.status <= STAT_REJECT;
				end else if (count_q >= CW'(TABLE_DEPTH)) begin
					res_q.status <= STAT_FULL;
				end
			end
			S_UAPPLY: hint_q <= {17'd0, rand_val};
			S_KAPPLY: hint_q <= {17'd0, rand_val} + KERN_LOW;
			S_SCAN_START: begin
				hint_q    <= hint_align;
				hintend_q <= hint_align + req_q.length;
				idx_q     <= '0;
				pass_q    <= 1'b0;
				cand_ok_q <= 1'b0;
			end
			S_RETRY: begin
				hint_q    <= cand_q;
				hintend_q <= cand_q + req_q.length;
				idx_q     <= '0;
				pass_q    <= 1'b1;
			end
			S_SCAN_A: begin
				if (fit_now) begin
					slot_q <= idx_q;
					k_q    <= count_q[AW-1:0];
				end
				diff_q    <= ent.base - prev_end_q;
				new_end_q <= ent.base + ent.size;
			end
			S_SCAN_B: begin
				if (cand_hit) begin
					cand_ok_q    <= 1'b1;
					cand_slack_q <= slack;
					cand_q       <= prev_end_q;
				end
				prev_end_q <= new_end_q;
				idx_q      <= idx_q + AW'(1);
				if (last && !(!pass_q && (cand_ok_q || cand_hit))) begin
					res_q.status <= STAT_REJECT;
				end
			end
			S_INS_WR: k_q <= k_q - AW'(1);
			S_INS_SLOT: res_q.region_start <= hint_q;
			S_FIND_START: idx_q <= '0;
			S_FIND_A: begin
				if (contain) begin
					if (req_q.action == ACT_LOOKUP) begin
						res_q <= '{status: STAT_OK, region_start: ent.base,
							region_length: ent.size, region_flags: ent.flags,
							region_file: ent.file, region_file_offset: ent.offset,
							region_disk_size: ent.disk};
					end else if (ent.base != req_q.address) begin
						res_q.status <= STAT_NOT_FOUND;
					end else begin
						res_q.region_start <= req_q.address;
						k_q                <= idx_q;
					end
				end else begin
					idx_q <= idx_q + AW'(1);
					if (last) begin
						res_q.status <= STAT_NOT_FOUND;
					end
				end
			end
			S_REM_WR: k_q <= k_q + AW'(1);
			S_FINISH: begin
				if (take) begin
					rsp_q <= res_q;
				end
			end
			default: ;
		endcase
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_rsp_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q) == S_FINISH)
		else $error("result word appeared outside finish");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CW'(1)) && (count_q <= CW'(TABLE_DEPTH)))
		else $error("region count out of range");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("accepted word did not start work");

	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS_WR || state_q == S_INS_SLOT) |-> count_q < CW'(TABLE_DEPTH))
		else $error("insert into full table");

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// testbench for sorted_region_best_fit_allocator_core: random and directed add, remove,
// lookup and bad-action words checked against a behavioural table model kept in the bench
// depends on srbf_pkg and the core
`timescale 1ns / 1ps

module tb;
	import srbf_pkg::*;

	localparam int DEPTH = 64;
	localparam int IDLE_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	sorted_region_best_fit_allocator_core #(.TABLE_DEPTH(DEPTH)) DUT (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_stall(req_stall),
		.req(req), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	always #5 clk = ~clk;

	// model of the region table
	entry_t tbl [DEPTH];
	int unsigned live;
	logic [31:0] seed;

	rsp_t pending_rsp [$];
	int errors = 0;
	int words_sent = 0;
	int words_checked = 0;
	int idle_cycles = 0;
	bit hold_off = 1'b0;
	int stall_mode = 0;
	int n_add_ok = 0, n_full = 0, n_lookup_hit = 0, n_remove_ok = 0;

	function automatic logic [31:0] next_rand();
		seed = seed * LCG_MUL + LCG_INC;
		return (seed >> 16) % 32'd32768;
	endfunction

	function automatic bit gap_ok(logic [31:0] s, logic [31:0] len, logic [6:0] f);
		logic [31:0] e;
		e = s + len;
		if (f[F_USER] && e >= USER_TOP)
			return 1'b0;
		if (f[F_KERNEL] && (s < KERN_LOW || e > KERN_HIGH))
			return 1'b0;
		return 1'b1;
	endfunction

	function automatic bit place_region(logic [31:0] hint, logic [31:0] len,
			logic [6:0] f, output int slot, inout bit have, inout logic [31:0] best,
			inout logic [31:0] best_slack);
		logic [31:0] pend, slk;
		slot = 0;
		if (tbl[0].base > hint + len)
			return 1'b1;
		for (int i = 1; i < live; i++) begin
			pend = tbl[i-1].base + tbl[i-1].size;
			if (pend <= hint && tbl[i].base > hint + len) begin
				slot = i;
				return 1'b1;
			end
			if (tbl[i].base - pend >= len && gap_ok(pend, len, f)) begin
				slk = tbl[i].base - pend - len;
				if (!have || slk < best_slack) begin
					have = 1'b1;
					best_slack = slk;
					best = pend;
				end
			end
		end
		return 1'b0;
	endfunction

	function automatic bit find_holder(logic [31:0] a, output int idx);
		idx = 0;
		for (int i = 0; i < live; i++)
			if (a >= tbl[i].base && a < tbl[i].base + tbl[i].size) begin
				idx = i;
				return 1'b1;
			end
		return 1'b0;
	endfunction

	function automatic rsp_t predict_region_op(req_t r);
		rsp_t o;
		logic [31:0] hint, best, best_slack;
		logic [6:0] f;
		bit have, fit;
		int slot, idx;
		o = '0;
		f = r.map_flags;
		have = 1'b0;
		best = '0;
		best_slack = '0;
		case (r.action)
			ACT_ADD: begin
				if ((f[F_USER] && f[F_KERNEL]) || (f[F_SHARED] && f[F_PRIVATE]) ||
						(f[F_ANON] && f[F_FILE]) || (f[F_FILE] && r.file_handle == 0)) begin
					o.status = STAT_REJECT;
					return o;
				end
				if (live >= DEPTH) begin
					o.status = STAT_FULL;
					n_full++;
					return o;
				end
				hint = r.address;
				if (f[F_USER] && hint + r.length >= USER_TOP)
					hint = next_rand() % KERN_LOW;
				if (f[F_KERNEL] && (hint < KERN_LOW || hint + r.length > KERN_HIGH))
					hint = next_rand() % (KERN_HIGH - KERN_LOW) + KERN_LOW;
				hint &= ~PAGE_MASK;
				fit = place_region(hint, r.length, f, slot, have, best, best_slack);
				if (!fit && have) begin
					hint = best;
					fit = place_region(hint, r.length, f, slot, have, best, best_slack);
				end
				if (!fit) begin
					o.status = STAT_REJECT;
					return o;
				end
				for (int k = live; k > slot; k--)
					tbl[k] = tbl[k-1];
				tbl[slot] = '{base: hint, size: r.length, flags: f, file: r.file_handle,
					offset: r.file_offset, disk: r.disk_size};
				live++;
				o.status = STAT_OK;
				o.region_start = hint;
				n_add_ok++;
			end
			ACT_REMOVE: begin
				if (!find_holder(r.address, idx) || tbl[idx].base != r.address) begin
					o.status = STAT_NOT_FOUND;
					return o;
				end
				if (tbl[idx].base == 0)
					tbl[idx].size = '0;
				else begin
					for (int k = idx; k + 1 < live; k++)
						tbl[k] = tbl[k+1];
					live--;
				end
				o.status = STAT_OK;
				o.region_start = r.address;
				n_remove_ok++;
			end
			ACT_LOOKUP: begin
				if (!find_holder(r.address, idx)) begin
					o.status = STAT_NOT_FOUND;
					return o;
				end
				o.status = STAT_OK;
				o.region_start = tbl[idx].base;
				o.region_length = tbl[idx].size;
				o.region_flags = tbl[idx].flags;
				o.region_file = tbl[idx].file;
				o.region_file_offset = tbl[idx].offset;
				o.region_disk_size = tbl[idx].disk;
				n_lookup_hit++;
			end
			default: o.status = STAT_REJECT;
		endcase
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("error at %0t: word %0d %s got %h expected %h", $realtime, words_checked,
			what, got, want);
		errors++;
	endtask

	// result checker
	always @(posedge clk) begin
		rsp_t e;
		if (rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch("unexpected word", 32'(rsp.status), 32'hFFFF_FFFF);
			end else begin
				e = pending_rsp.pop_front();
				if (rsp.status !== e.status)
					report_mismatch("status", 32'(rsp.status), 32'(e.status));
				if (rsp.region_start !== e.region_start)
					report_mismatch("region_start", rsp.region_start, e.region_start);
				if (rsp.region_length !== e.region_length)
					report_mismatch("region_length", rsp.region_length, e.region_length);
				if (rsp.region_flags !== e.region_flags)
					report_mismatch("region_flags", 32'(rsp.region_flags), 32'(e.region_flags));
				if (rsp.region_file !== e.region_file)
					report_mismatch("region_file", 32'(rsp.region_file), 32'(e.region_file));
				if (rsp.region_file_offset !== e.region_file_offset)
					report_mismatch("region_file_offset", rsp.region_file_offset,
						e.region_file_offset);
				if (rsp.region_disk_size !== e.region_disk_size)
					report_mismatch("region_disk_size", rsp.region_disk_size,
						e.region_disk_size);
			end
			words_checked++;
		end
	end

	// receiver stall pattern, with a long hold-off on request
	always @(posedge clk) begin
		if (!arst_n)
			rsp_stall <= 1'b0;
		else if (hold_off)
			rsp_stall <= 1'b1;
		else case (stall_mode)
			0: rsp_stall <= 1'b0;
			1: rsp_stall <= ($urandom_range(0, 3) == 0);
			default: rsp_stall <= ($urandom_range(0, 9) < 7);
		endcase
	end

	always @(posedge clk) begin
		if (words_checked > 0 && words_sent > 0 && ($urandom_range(0, 499) == 0))
			stall_mode <= $urandom_range(0, 2);
	end

	// watchdog
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || hold_off)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("sorted_region_best_fit_allocator_core: mismatch");
			$finish;
		end
	end

	int burst_left = 0;

	// offer one word and wait for it to be taken; valid stays up within a burst
	task automatic send_word(req_t r);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		burst_left--;
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		pending_rsp.push_back(predict_region_op(r));
		words_sent++;
		if (burst_left == 0)
			req_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		if (burst_left != 0) begin
			burst_left = 0;
			req_valid <= 1'b0;
		end
		while (pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	function automatic req_t make_word(logic [1:0] act, logic [31:0] a, logic [31:0] len,
			logic [6:0] f, logic [15:0] fh);
		req_t r;
		r.action = act;
		r.address = a;
		r.length = len;
		r.map_flags = f;
		r.file_handle = fh;
		r.file_offset = $urandom;
		r.disk_size = $urandom;
		return r;
	endfunction

	// a sane flag set: at most one of each exclusive pair
	function automatic logic [6:0] legal_flags();
		logic [6:0] f;
		f = $urandom;
		if (f[F_USER] && f[F_KERNEL])
			f[$urandom_range(0, 1)] = 1'b0;
		if (f[F_SHARED] && f[F_PRIVATE])
			f[F_SHARED + $urandom_range(0, 1)] = 1'b0;
		if (f[F_ANON] && f[F_FILE])
			f[F_ANON + $urandom_range(0, 1)] = 1'b0;
		return f;
	endfunction

	function automatic logic [31:0] pick_live_address(bit exact_base);
		int i;
		if (live <= 1)
			return $urandom;
		i = $urandom_range(0, live - 2);
		if (exact_base || tbl[i].size == 0)
			return tbl[i].base;
		return tbl[i].base + ($urandom % tbl[i].size);
	endfunction

	task automatic test_directed();
		send_word(make_word(ACT_LOOKUP, 32'h0, 0, 0, 0));
		send_word(make_word(ACT_REMOVE, 32'hFFFF_FFFF, 0, 0, 0));
		// each contradictory flag pair, and file without a handle
		send_word(make_word(ACT_ADD, 32'h1000, 32'h1000, 7'h03, 0));
		send_word(make_word(ACT_ADD, 32'h1000, 32'h1000, 7'h0C, 0));
		send_word(make_word(ACT_ADD, 32'h1000, 32'h1000, 7'h30, 16'h1));
		send_word(make_word(ACT_ADD, 32'h1000, 32'h1000, 7'h20, 16'h0));
		// plain adds, hint at zero, then a collision that needs the best-fit retry
		send_word(make_word(ACT_ADD, 32'h0, 32'h2000, 7'h48, 0));
		send_word(make_word(ACT_ADD, 32'h0000_5123, 32'h1000, 7'h24, 16'hFFFF));
		send_word(make_word(ACT_ADD, 32'h0000_0800, 32'h1000, 7'h01, 0));
		send_word(make_word(ACT_ADD, 32'h0, 32'hFFFF_FFFF, 7'h00, 0));
		// window clamps
		send_word(make_word(ACT_ADD, 32'hFFFF_FFFF, 32'h4000, 7'h01, 0));
		send_word(make_word(ACT_ADD, 32'h0000_1000, 32'h4000, 7'h02, 0));
		send_word(make_word(ACT_ADD, 32'hFFC0_0000, 32'h0020_0000, 7'h7E & 7'h12, 0));
		send_word(make_word(ACT_LOOKUP, 32'h0000_1FFF, 0, 0, 0));
		send_word(make_word(ACT_LOOKUP, 32'h0000_5000, 0, 0, 0));
		send_word(make_word(ACT_LOOKUP, 32'hFFFF_FFFF, 0, 0, 0));
		send_word(make_word(ACT_REMOVE, 32'h0000_1000, 0, 0, 0));
		send_word(make_word(ACT_REMOVE, 32'h0, 0, 0, 0));
		send_word(make_word(ACT_LOOKUP, 32'h0, 0, 0, 0));
		send_word(make_word(ACT_REMOVE, 32'h0000_5000, 0, 0, 0));
		send_word(make_word(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'h7F, 16'hFFFF));
		wait_drained();
	endtask

	// fill the table to the top and beyond, with the receiver held off for a while
	task automatic test_table_full();
		fork
			begin
				@(posedge clk);
				hold_off = 1'b1;
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
		join_none
		for (int i = 0; i < 75; i++)
			send_word(make_word(ACT_ADD, 32'h1000 * ($urandom_range(0, 400)),
				32'h1000 * $urandom_range(1, 3), legal_flags() & 7'h5C, 0));
		wait_drained();
		// empty it again by exact base; wrapped regions can never be removed
		for (int n = 0; n < 2 * DEPTH && live > 1 && !(live == 2 && tbl[0].base == 0); n++)
			send_word(make_word(ACT_REMOVE, pick_live_address(1'b1), 0, 0, 0));
		wait_drained();
	endtask

	task automatic test_random(int count);
		req_t r;
		int sel;
		for (int n = 0; n < count; n++) begin
			sel = $urandom_range(0, 99);
			if (sel < 40) begin
				r = make_word(ACT_ADD, $urandom, 0, legal_flags(), $urandom);
				// mostly modest sizes, some huge
				case ($urandom_range(0, 9))
					0: r.length = $urandom;
					1: r.length = $urandom_range(0, 4095);
					default: r.length = $urandom_range(1, 64) << 12;
				endcase
				if ($urandom_range(0, 2) != 0)
					r.address = $urandom_range(0, 32'h0100_0000);
				if ($urandom_range(0, 15) == 0)
					r.map_flags = $urandom;
			end else if (sel < 65) begin
				r = make_word(ACT_LOOKUP, ($urandom_range(0, 3) == 0) ? $urandom :
					pick_live_address(1'b0), $urandom, $urandom, $urandom);
			end else if (sel < 95) begin
				r = make_word(ACT_REMOVE, ($urandom_range(0, 5) == 0) ? $urandom :
					pick_live_address($urandom_range(0, 4) != 0), $urandom, $urandom, $urandom);
			end else begin
				r = make_word(2'd3, $urandom, $urandom, $urandom, $urandom);
			end
			send_word(r);
		end
		wait_drained();
	endtask

	initial begin
		for (int i = 0; i < DEPTH; i++)
			tbl[i] = '0;
		tbl[0] = SENTINEL;
		live = 1;
		seed = SEED_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_table_full();
		test_random(1200);
		repeat (50) @(posedge clk);
		$display("covered %0d words: %0d adds placed, %0d full-table rejects,",
			words_sent, n_add_ok, n_full);
		$display("%0d lookups hit, %0d removes done, with stalls and bursty input",
			n_lookup_hit, n_remove_ok);
		if (errors == 0 && pending_rsp.size() == 0)
			$display("sorted_region_best_fit_allocator_core: match");
		else
			$display("sorted_region_best_fit_allocator_core: mismatch");
		$finish;
	end

endmodule
